@@ rtl/ca_name_vector_checker_top_macros.svh @@
// Assertion macros shared by the checker RTL.
`ifndef CA_NAME_VECTOR_CHECKER_TOP_MACROS_SVH
`define CA_NAME_VECTOR_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CNVC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CNVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cnvc_pkg.sv @@
package cnvc_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned NAMES_W  = 15;
    localparam int unsigned ERR_W    = 3;
    localparam int unsigned RESULT_W = 1 + ERR_W + NAMES_W;
    localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 17'd65538;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd65537;
    localparam logic [COUNT_W-1:0] PREFIX_LEN = 17'd2;
    localparam logic [NAMES_W-1:0] NAMES_SAT = '1;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 3'd0,
        ERR_SIZE       = 3'd1,
        ERR_LEN_MISMATCH = 3'd2,
        ERR_NAME_LEN_CUT = 3'd3,
        ERR_NAME_BAD   = 3'd4,
        ERR_LIST_EMPTY = 3'd5
    } err_code_t;

endpackage

@@ rtl/ca_name_vector_checker_top.sv @@
// Channel   | Dir | Beat contents (low bit first)
// ----------+-----+------------------------------------------------------
// s_axis    | in  | tdata: data_byte[7:0]; tlast: last
// m_axis    | out | tdata: ok, error_code[2:0], name_count[14:0], zero pad
// cfg       | in  | cfg_wdata: require_nonempty, written when cfg_we is high
//
// One byte is accepted per cycle while s_axis_tready is high; the parse state updates at the accepting edge.
// A verdict appears on m_axis in the cycle after the byte flagged tlast is taken.
// s_axis stalls only while a verdict waits in the output register and m_axis_tready is low.
// rst_n clears the parse state, the output register and require_nonempty.
`include "ca_name_vector_checker_top_macros.svh"

module ca_name_vector_checker_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,      // require_nonempty
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [cnvc_pkg::DATA_W-1:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic                         s_axis_tlast,   // last
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [cnvc_pkg::M_DATA_W-1:0] m_axis_tdata   // ok, error_code, name_count, pad
);
    import cnvc_pkg::*;

    typedef enum logic [2:0] {
        PH_OUTER_HI,
        PH_OUTER_LO,
        PH_NAME_HI,
        PH_NAME_LO,
        PH_BODY,
        PH_SKIP
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [LEN_W-1:0]     declared_length_reg, declared_length_next;
    logic [LEN_W-1:0]     name_left_reg, name_left_next;
    logic [DATA_W-1:0]    name_len_high_reg, name_len_high_next;
    err_code_t            first_error_reg, first_error_next;
    logic [NAMES_W-1:0]   names_seen_reg, names_seen_next;
    logic                 require_nonempty_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 ok_reg, ok_next;
    err_code_t            err_reg, err_next;
    logic [NAMES_W-1:0]   count_reg, count_next;

    logic                 in_acc;
    logic [LEN_W-1:0]     name_len;
    err_code_t            name_err;
    err_code_t            verdict;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign name_len      = {name_len_high_reg, s_axis_tdata};

    always_comb
    begin
        phase_next           = phase_reg;
        byte_count_next      = byte_count_reg;
        declared_length_next = declared_length_reg;
        name_left_next       = name_left_reg;
        name_len_high_next   = name_len_high_reg;
        first_error_next     = first_error_reg;
        names_seen_next      = names_seen_reg;

        if (byte_count_reg < COUNT_SAT)
        begin
            byte_count_next = byte_count_reg + COUNT_W'(1);
        end

        unique case (phase_reg)
            PH_OUTER_HI:
            begin
                declared_length_next = {s_axis_tdata, DATA_W'(0)};
                phase_next           = PH_OUTER_LO;
            end
            PH_OUTER_LO:
            begin
                declared_length_next = {declared_length_reg[LEN_W-1:DATA_W], s_axis_tdata};
                phase_next           = PH_NAME_HI;
            end
            PH_NAME_HI:
            begin
                name_len_high_next = s_axis_tdata;
                phase_next         = PH_NAME_LO;
            end
            PH_NAME_LO:
            begin
                if (name_len == '0)
                begin
                    if (first_error_reg == ERR_NONE)
                    begin
                        first_error_next = ERR_NAME_BAD;
                    end
                    phase_next = PH_SKIP;
                end
                else
                begin
                    name_left_next = name_len;
                    phase_next     = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (name_left_reg != '0)
                begin
                    name_left_next = name_left_reg - LEN_W'(1);
                end
                if (name_left_next == '0)
                begin
                    if (names_seen_reg != NAMES_SAT)
                    begin
                        names_seen_next = names_seen_reg + NAMES_W'(1);
                    end
                    phase_next = PH_NAME_HI;
                end
            end
            PH_SKIP:
            begin
                phase_next = PH_SKIP;
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        // fold in a vector that ends mid-name
        name_err = first_error_next;
        if (first_error_next == ERR_NONE)
        begin
            if (phase_next == PH_NAME_LO)
            begin
                name_err = ERR_NAME_LEN_CUT;
            end
            else if (phase_next == PH_BODY && name_left_next != '0)
            begin
                name_err = ERR_NAME_BAD;
            end
        end

        priority if (byte_count_next < PREFIX_LEN || byte_count_next > COUNT_MAX)
        begin
            verdict = ERR_SIZE;
        end
        else if ({1'b0, declared_length_next} != byte_count_next - PREFIX_LEN)
        begin
            verdict = ERR_LEN_MISMATCH;
        end
        else if (name_err != ERR_NONE)
        begin
            verdict = name_err;
        end
        else if (require_nonempty_reg && declared_length_next == '0)
        begin
            verdict = ERR_LIST_EMPTY;
        end
        else
        begin
            verdict = ERR_NONE;
        end

        out_valid_next = out_valid_reg && !m_axis_tready;
        ok_next        = ok_reg;
        err_next       = err_reg;
        count_next     = count_reg;

        if (in_acc && s_axis_tlast)
        begin
            out_valid_next = 1'b1;
            ok_next        = (verdict == ERR_NONE);
            err_next       = verdict;
            count_next     = (verdict == ERR_NONE) ? names_seen_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_OUTER_HI;
            byte_count_reg       <= '0;
            declared_length_reg  <= '0;
            name_left_reg        <= '0;
            name_len_high_reg    <= '0;
            first_error_reg      <= ERR_NONE;
            names_seen_reg       <= '0;
            require_nonempty_reg <= 1'b0;
            out_valid_reg        <= 1'b0;
            ok_reg               <= 1'b0;
            err_reg              <= ERR_NONE;
            count_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                require_nonempty_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            if (in_acc)
            begin
                if (s_axis_tlast)
                begin
                    // start a fresh vector on the next beat
                    phase_reg           <= PH_OUTER_HI;
                    byte_count_reg      <= '0;
                    declared_length_reg <= '0;
                    name_left_reg       <= '0;
                    name_len_high_reg   <= '0;
                    first_error_reg     <= ERR_NONE;
                    names_seen_reg      <= '0;
                end
                else
                begin
                    phase_reg           <= phase_next;
                    byte_count_reg      <= byte_count_next;
                    declared_length_reg <= declared_length_next;
                    name_left_reg       <= name_left_next;
                    name_len_high_reg   <= name_len_high_next;
                    first_error_reg     <= first_error_next;
                    names_seen_reg      <= names_seen_next;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_DATA_W - RESULT_W)'(0), count_reg, err_reg, ok_reg};

    `CNVC_ASSERT_NOW(a_ok_iff_no_error, m_axis_tvalid, ok_reg == (err_reg == ERR_NONE), "ok flag disagrees with error code")
    `CNVC_ASSERT_NOW(a_count_zero_on_fail, m_axis_tvalid && !ok_reg, count_reg == '0, "name count nonzero on failed vector")
    `CNVC_ASSERT_NEXT(a_last_clears_parse, in_acc && s_axis_tlast, byte_count_reg == '0 && phase_reg == PH_OUTER_HI && m_axis_tvalid, "final beat did not restart parse or post verdict")
    `CNVC_ASSERT_NOW(a_skip_has_error, phase_reg == PH_SKIP, first_error_reg == ERR_NAME_BAD, "skip phase without a recorded name error")

endmodule
